// File: hw/rtl/bcomp_pkg.sv
// ----------------------------------------------------------------------------
// bcomp_pkg
// Shared constants and helpers for the barometer compensation block.
// ----------------------------------------------------------------------------
package bcomp_pkg;

  // datapath word width of the shared multiplier and divider
  localparam int unsigned DW = 32;

  // oversampling setting, only the low two bits count
  localparam logic [1:0] OSS = 2'd3;
  localparam int unsigned UP_SHIFT = 8 - OSS;

  // compensation constants
  localparam logic [DW-1:0] C_B6_OFS  = 32'd4000;
  localparam logic [DW-1:0] C_P_MUL1  = 32'd3038;
  localparam logic [DW-1:0] C_P_MUL2  = 32'hFFFF_E343; // -7357
  localparam logic [DW-1:0] C_P_OFS   = 32'd3791;
  localparam logic [DW-1:0] C_B4_OFS  = 32'd32768;
  localparam logic [DW-1:0] C_B7_MUL  = DW'(50000 >> OSS);

  // register indexes
  localparam logic [2:0] REG_AC1 = 3'd0;
  localparam logic [2:0] REG_AC2 = 3'd1;
  localparam logic [2:0] REG_AC3 = 3'd2;
  localparam logic [2:0] REG_AC456 = 3'd3;
  localparam logic [2:0] REG_B1 = 3'd4;
  localparam logic [2:0] REG_B2 = 3'd5;
  localparam logic [2:0] REG_MC = 3'd6;
  localparam logic [2:0] REG_MD = 3'd7;

  // sign extend a 16-bit coefficient to a datapath word
  function automatic logic [DW-1:0] sx16(input logic [15:0] v);
    return {{(DW-16){v[15]}}, v};
  endfunction

endpackage

// File: hw/rtl/barometer_compensation.sv
// ----------------------------------------------------------------------------
// barometer_compensation
// Integer temperature and pressure compensation of raw barometer readings.
// ----------------------------------------------------------------------------
// One reading is handled at a time. Temperature and pressure readings both
// pass through the 32-step serial divider, unless the divisor is zero, and
// the single shared 32x32 multiplier that a small sequencer steps through
// the compensation terms. A result waits in an output register, and a new
// reading is taken once the sequencer is idle. The stored B5 starts at zero.
module barometer_compensation
  import bcomp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_command,
  input  logic [23:0]        in_raw_reading,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_reading_kind,
  output logic signed [11:0] out_temperature_tenths,
  output logic [17:0]        out_pressure_pascal,
  output logic               out_divide_error
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_T0   = 5'd1;
  localparam logic [4:0] S_T1   = 5'd2;
  localparam logic [4:0] S_T2   = 5'd3;
  localparam logic [4:0] S_T3   = 5'd4;
  localparam logic [4:0] S_T4   = 5'd5;
  localparam logic [4:0] S_P0   = 5'd6;
  localparam logic [4:0] S_P1   = 5'd7;
  localparam logic [4:0] S_P2   = 5'd8;
  localparam logic [4:0] S_P3   = 5'd9;
  localparam logic [4:0] S_P4   = 5'd10;
  localparam logic [4:0] S_P5   = 5'd11;
  localparam logic [4:0] S_P6   = 5'd12;
  localparam logic [4:0] S_P7   = 5'd13;
  localparam logic [4:0] S_P8   = 5'd14;
  localparam logic [4:0] S_P9   = 5'd15;
  localparam logic [4:0] S_P10  = 5'd16;
  localparam logic [4:0] S_P11  = 5'd17;
  localparam logic [4:0] S_P12  = 5'd18;
  localparam logic [4:0] S_P13  = 5'd19;
  localparam logic [4:0] S_P14  = 5'd20;
  localparam logic [4:0] S_P15  = 5'd21;
  localparam logic [4:0] S_DONE = 5'd22;

  // calibration registers
  logic [15:0] ac1_r, ac2_r, ac3_r, b1_r, b2_r, mc_r, md_r;
  logic [47:0] ac456_r;

  logic [4:0]     state_r, state_nxt;
  logic           cmd_r;
  logic [23:0]    raw_r;
  logic [DW-1:0]  b5_r, b6_r, sq_r, acc_r, x1_r, x3_r, b3_r, b4_r, b7_r, p_r;
  logic [DW-1:0]  mul_r, opa, opb;
  logic [2*DW-1:0] mul_full;
  logic           neg_r, err_r;
  logic [11:0]    temp_r;
  logic [17:0]    pres_r;
  logic           out_valid_r, out_kind_r, out_err_r;
  logic [11:0]    out_temp_r;
  logic [17:0]    out_pres_r;

  logic           div_start, div_done;
  logic [DW-1:0]  div_num, div_den, div_q;

  logic [15:0]    ac4, ac5, ac6;
  logic [DW-1:0]  x1_t, den_t, num_t, q_s, b5_t, t_t, s_t, sp_t, x2_t, up_w;
  logic [DW-1:0]  p_t;
  logic [16:0]    ut_d;

  assign ac4 = ac456_r[47:32];
  assign ac5 = ac456_r[31:16];
  assign ac6 = ac456_r[15:0];

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ac1_r   <= 16'd408;
      ac2_r   <= 16'hFFB8;
      ac3_r   <= 16'hC7D1;
      ac456_r <= 48'd140623671024241;
      b1_r    <= 16'd6190;
      b2_r    <= 16'd4;
      mc_r    <= 16'hDDF9;
      md_r    <= 16'd2868;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AC1:   ac1_r   <= cfg_wdata[15:0];
        REG_AC2:   ac2_r   <= cfg_wdata[15:0];
        REG_AC3:   ac3_r   <= cfg_wdata[15:0];
        REG_AC456: ac456_r <= cfg_wdata;
        REG_B1:    b1_r    <= cfg_wdata[15:0];
        REG_B2:    b2_r    <= cfg_wdata[15:0];
        REG_MC:    mc_r    <= cfg_wdata[15:0];
        REG_MD:    md_r    <= cfg_wdata[15:0];
        default:   ;
      endcase
    end
  end

  // shared multiplier operand select
  assign ut_d = {1'b0, raw_r[15:0]} - {1'b0, ac6};
  assign up_w = DW'(raw_r >> UP_SHIFT);
  always_comb begin
    opa = '0;
    opb = '0;
    unique case (state_r)
      S_T0: begin
        opa = {{(DW-17){ut_d[16]}}, ut_d};
        opb = {{(DW-16){1'b0}}, ac5};
      end
      S_P1: begin
        opa = b6_r;
        opb = b6_r;
      end
      S_P2: begin
        opa = sx16(ac2_r);
        opb = b6_r;
      end
      S_P3: begin
        opa = sx16(b2_r);
        opb = sq_r;
      end
      S_P4: begin
        opa = sx16(ac3_r);
        opb = b6_r;
      end
      S_P5: begin
        opa = sx16(b1_r);
        opb = sq_r;
      end
      S_P7: begin
        opa = {{(DW-16){1'b0}}, ac4};
        opb = x3_r + C_B4_OFS;
      end
      S_P8: begin
        opa = up_w - b3_r;
        opb = C_B7_MUL;
      end
      S_P11: begin
        opa = DW'($signed(p_r) >>> 8);
        opb = DW'($signed(p_r) >>> 8);
      end
      S_P12: begin
        opa = mul_r;
        opb = C_P_MUL1;
      end
      S_P13: begin
        opa = C_P_MUL2;
        opb = p_r;
      end
      default: ;
    endcase
  end

  assign mul_full = {{DW{1'b0}}, opa} * {{DW{1'b0}}, opb};

  always_ff @(posedge clk) begin
    mul_r <= mul_full[DW-1:0];
  end

  // combinational terms for the sequencer
  assign x1_t  = DW'($signed(mul_r) >>> 15);
  assign den_t = x1_t + sx16(md_r);
  assign num_t = sx16(mc_r) << 11;
  assign q_s   = neg_r ? (~div_q + 1'b1) : div_q;
  assign b5_t  = x1_r + acc_r;
  assign t_t   = ((sx16(ac1_r) << 2) + x3_r) << OSS;
  assign s_t   = t_t + 32'd2;
  assign x2_t  = DW'($signed(mul_r) >>> 16);
  assign sp_t  = DW'($signed(b5_r + 32'd8) >>> 4);
  assign p_t   = p_r + DW'($signed(acc_r) >>> 4);

  // divider operands
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state_r)
      S_T1: begin
        div_start = (den_t != '0);
        div_num   = num_t[DW-1] ? (~num_t + 1'b1) : num_t;
        div_den   = den_t[DW-1] ? (~den_t + 1'b1) : den_t;
      end
      S_P9: begin
        div_start = (b4_r != '0);
        div_num   = mul_r[DW-1] ? mul_r : (mul_r << 1);
        div_den   = b4_r;
      end
      default: ;
    endcase
  end

  bcomp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = in_command ? S_P0 : S_T0;
      S_T0:   state_nxt = S_T1;
      S_T1:   state_nxt = (den_t == '0) ? S_DONE : S_T2;
      S_T2:   if (div_done) state_nxt = S_T3;
      S_T3:   state_nxt = S_T4;
      S_T4:   state_nxt = S_DONE;
      S_P0:   state_nxt = S_P1;
      S_P1:   state_nxt = S_P2;
      S_P2:   state_nxt = S_P3;
      S_P3:   state_nxt = S_P4;
      S_P4:   state_nxt = S_P5;
      S_P5:   state_nxt = S_P6;
      S_P6:   state_nxt = S_P7;
      S_P7:   state_nxt = S_P8;
      S_P8:   state_nxt = S_P9;
      S_P9:   state_nxt = (b4_r == '0) ? S_DONE : S_P10;
      S_P10:  if (div_done) state_nxt = S_P11;
      S_P11:  state_nxt = S_P12;
      S_P12:  state_nxt = S_P13;
      S_P13:  state_nxt = S_P14;
      S_P14:  state_nxt = S_P15;
      S_P15:  state_nxt = S_DONE;
      S_DONE: if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      b5_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_T3) b5_r <= b5_t;
      if (state_r == S_DONE && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        cmd_r  <= in_command;
        raw_r  <= in_raw_reading;
        err_r  <= 1'b0;
        temp_r <= '0;
        pres_r <= '0;
      end
      S_T1: begin
        x1_r  <= x1_t;
        neg_r <= num_t[DW-1] ^ den_t[DW-1];
        if (den_t == '0) err_r <= 1'b1;
      end
      S_T2: if (div_done) acc_r <= q_s;
      S_T4: begin
        // saturate to the 12-bit field
        if ($signed(sp_t) > 32'sd2047) temp_r <= 12'h7FF;
        else if ($signed(sp_t) < -32'sd2048) temp_r <= 12'h800;
        else temp_r <= sp_t[11:0];
      end
      S_P0: b6_r <= b5_r - C_B6_OFS;
      S_P2: sq_r <= DW'($signed(mul_r) >>> 12);
      S_P3: acc_r <= DW'($signed(mul_r) >>> 11);
      S_P4: x3_r <= DW'($signed(mul_r) >>> 11) + acc_r;
      S_P5: begin
        acc_r <= DW'($signed(mul_r) >>> 13);
        // signed divide by four, truncating toward zero
        b3_r  <= s_t[DW-1] ? DW'($signed(s_t + 32'd3) >>> 2) : DW'($signed(s_t) >>> 2);
      end
      S_P6: x3_r <= DW'($signed(acc_r + x2_t + 32'd2) >>> 2);
      S_P8: b4_r <= mul_r >> 15;
      S_P9: begin
        b7_r <= mul_r;
        if (b4_r == '0) err_r <= 1'b1;
      end
      S_P10: if (div_done) p_r <= b7_r[DW-1] ? (div_q << 1) : div_q;
      S_P13: acc_r <= x2_t;
      S_P14: acc_r <= acc_r + x2_t + C_P_OFS;
      S_P15: begin
        if (p_t[DW-1]) pres_r <= '0;
        else if (p_t > 32'd262143) pres_r <= 18'h3FFFF;
        else pres_r <= p_t[17:0];
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_kind_r <= cmd_r;
      out_temp_r <= temp_r;
      out_pres_r <= pres_r;
      out_err_r  <= err_r;
    end
  end

  assign in_ready               = (state_r == S_IDLE);
  assign out_valid              = out_valid_r;
  assign out_reading_kind       = out_kind_r;
  assign out_temperature_tenths = out_temp_r;
  assign out_pressure_pascal    = out_pres_r;
  assign out_divide_error       = out_err_r;

endmodule

// File: hw/rtl/bcomp_div.sv
// ----------------------------------------------------------------------------
// bcomp_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bcomp_div
  import bcomp_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [DW-1:0] quot
);

  logic [DW-1:0]         rem_r, quo_r, den_r;
  logic [$clog2(DW)-1:0] cnt_r;
  logic                  busy_r, done_r;
  logic [DW:0]           sh;
  logic [DW+1:0]         diff;

  // trial subtract of the shifted remainder
  assign sh   = {rem_r, quo_r[DW-1]};
  assign diff = {1'b0, sh} - {2'b00, den_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == $clog2(DW)'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      if (!diff[DW+1]) begin
        rem_r <= diff[DW-1:0];
        quo_r <= {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_r <= sh[DW-1:0];
        quo_r <= {quo_r[DW-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule
